// ===== hdl/sq_pkg.sv =====
// Shared types and constants for the sleep queue block.
package sq_pkg;

  // Field widths of the transaction payloads.
  localparam int unsigned HANDLE_BITS = 8;
  localparam int unsigned TICK_BITS   = 16;
  localparam int unsigned COUNT_BITS  = 5;

  // A countdown of all ones means the entry waits forever.
  localparam logic [TICK_BITS-1:0] FOREVER = '1;

  // Command codes.
  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_REM  = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5,
    ST_WOKEN    = 3'd6,
    ST_TICKDONE = 3'd7
  } status_t;

  // Input transaction.
  typedef struct packed {
    cmd_t                        cmd;
    logic [HANDLE_BITS-1:0]      task_handle;
    logic signed [TICK_BITS-1:0] sleep_ticks;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    status_t                status;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [COUNT_BITS-1:0]  woken_count;
    logic                   last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic enq;     // write a new entry at the tail
    logic init;    // latch the command and clear the walk counters
    logic issue;   // read the next entry of the walk
    logic finish;  // commit the new count and send the closing result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;    // no valid entries
    logic rd_last;  // the read being issued is the last valid entry
  } dp_sts_t;

endpackage

// ===== hdl/sq_ctrl.sv =====
// Controller state machine that sequences the queue walk.
module sq_ctrl
  import sq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  cmd_t    in_cmd,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  // Commands to the datapath follow the current state.
  always_comb begin
    cmd_o.enq    = accept && (state_r == S_IDLE) && (in_cmd == CMD_ENQ);
    cmd_o.init   = accept && (state_r == S_IDLE) && (in_cmd != CMD_ENQ);
    cmd_o.issue  = (state_r == S_SCAN);
    cmd_o.finish = (state_r == S_FINISH);
  end

  // Next state: an empty queue skips the walk entirely.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_o.init) begin
          state_nxt = sts_i.empty ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.rd_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_FINISH;
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // State and the registered busy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  // A walk always closes and hands control back the cycle after.
  a_finish_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH |=> state_r == S_IDLE && !busy_r)
    else $error("walk did not return to idle after finishing");

  // An enqueue completes at acceptance and leaves the block free.
  a_enq_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.enq |=> !busy_r)
    else $error("enqueue left the block busy");

  // Any walking command holds the block busy on the next cycle.
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.init |=> busy_r && (state_r == S_SCAN || state_r == S_FINISH))
    else $error("walking command did not start a walk");

  // Issuing the last read always leads to the drain state.
  a_scan_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && sts_i.rd_last |=> state_r == S_DRAIN)
    else $error("scan did not drain after the last read");

endmodule

// ===== hdl/sq_dp.sv =====
// Datapath: queue memory, walk counters and the registered result stage.
module sq_dp
  import sq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned HANDLE_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd_i,
  output dp_sts_t   sts_o,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned HW = (HANDLE_WIDTH < HANDLE_BITS) ? HANDLE_WIDTH : HANDLE_BITS;
  localparam int unsigned EW = HW + TICK_BITS;

  // Queue storage: handle in the upper bits, countdown in the lower bits.
  logic [EW-1:0] mem [QUEUE_DEPTH];

  logic [CW-1:0]        count_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 rd_vld_r;
  logic [EW-1:0]        rd_data_r;
  logic [CW-1:0]        wr_idx_r;
  cmd_t                 op_r;
  logic [HW-1:0]        key_r;
  logic                 dropped_r;
  logic [HW-1:0]        saved_r;
  logic [CW-1:0]        woken_r;
  logic                 out_vld_r, out_vld_nxt;
  out_item_t            out_r, out_nxt;

  logic [HW-1:0]        in_key;
  logic [HW-1:0]        rd_h;
  logic [TICK_BITS-1:0] rd_c;
  logic [TICK_BITS-1:0] new_c;
  logic                 drop;
  logic                 full;
  logic                 mem_we;
  logic [IW-1:0]        mem_wa;
  logic [EW-1:0]        mem_wd;

  assign in_key = in_item.task_handle[HW-1:0];
  assign rd_h   = rd_data_r[EW-1:TICK_BITS];
  assign rd_c   = rd_data_r[TICK_BITS-1:0];
  assign full   = (count_r >= CW'(QUEUE_DEPTH));

  // Status back to the controller.
  assign sts_o.empty   = (count_r == '0);
  assign sts_o.rd_last = (CW'(rd_idx_r) == count_r - CW'(1));

  // Decide for the entry under inspection whether it leaves the queue.
  always_comb begin
    new_c = rd_c;
    drop  = 1'b0;
    unique case (op_r)
      CMD_DEQ: drop = !dropped_r;
      CMD_REM: drop = !dropped_r && (rd_h == key_r);
      CMD_TICK: begin
        if (rd_c != FOREVER) begin
          new_c = rd_c - TICK_BITS'(1);
        end
        drop = (rd_c == TICK_BITS'(1));
      end
      default: drop = 1'b0;
    endcase
  end

  // Single write port: tail append, or compaction of a kept entry.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = count_r[IW-1:0];
    mem_wd = {in_key, in_item.sleep_ticks};
    priority if (cmd_i.enq && !full) begin
      mem_we = 1'b1;
    end else if (rd_vld_r && !drop) begin
      mem_we = 1'b1;
      mem_wa = wr_idx_r[IW-1:0];
      mem_wd = {rd_h, new_c};
    end
  end

  // Memory with registered read; the read always runs ahead of the write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  // Result for the cycle: enqueue answer, wake report or closing result.
  always_comb begin
    out_vld_nxt = 1'b0;
    out_nxt     = '{status: ST_ENQUEUED, out_handle: '0, woken_count: '0, last: 1'b1};
    if (cmd_i.enq) begin
      out_vld_nxt    = 1'b1;
      out_nxt.status = full ? ST_FULL : ST_ENQUEUED;
    end else if (rd_vld_r && drop && (op_r == CMD_TICK)) begin
      out_vld_nxt        = 1'b1;
      out_nxt.status     = ST_WOKEN;
      out_nxt.out_handle = HANDLE_BITS'(rd_h);
      out_nxt.last       = 1'b0;
    end else if (cmd_i.finish) begin
      out_vld_nxt = 1'b1;
      unique case (op_r)
        CMD_DEQ: begin
          out_nxt.status     = dropped_r ? ST_DEQUEUED : ST_EMPTY;
          out_nxt.out_handle = dropped_r ? HANDLE_BITS'(saved_r) : '0;
        end
        CMD_REM: out_nxt.status = dropped_r ? ST_REMOVED : ST_NOTFOUND;
        CMD_TICK: begin
          out_nxt.status      = ST_TICKDONE;
          out_nxt.woken_count = COUNT_BITS'(woken_r);
        end
        default: out_nxt.status = ST_ENQUEUED;
      endcase
    end
  end

  // Walk control and queue bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      rd_idx_r  <= '0;
      rd_vld_r  <= 1'b0;
      wr_idx_r  <= '0;
      op_r      <= CMD_ENQ;
      dropped_r <= 1'b0;
      woken_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
      rd_vld_r  <= cmd_i.issue;
      if (cmd_i.enq && !full) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd_i.init) begin
        op_r      <= in_item.cmd;
        rd_idx_r  <= '0;
        wr_idx_r  <= '0;
        dropped_r <= 1'b0;
        woken_r   <= '0;
      end
      if (cmd_i.issue) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (rd_vld_r) begin
        if (drop) begin
          dropped_r <= 1'b1;
          if (op_r == CMD_TICK) begin
            woken_r <= woken_r + CW'(1);
          end
        end else begin
          wr_idx_r <= wr_idx_r + CW'(1);
        end
      end
      if (cmd_i.finish) begin
        count_r <= wr_idx_r;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd_i.init) begin
      key_r <= in_key;
    end
    if (rd_vld_r && drop && !dropped_r) begin
      saved_r <= rd_h;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

  // The entry count never passes the queue depth.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // Compaction never writes past the entries already inspected.
  a_wr_behind: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> wr_idx_r < count_r)
    else $error("compaction write index overran the queue");

  // No entry is still being inspected when the walk closes.
  a_no_late_entry: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |-> !rd_vld_r && !cmd_i.issue)
    else $error("walk closed with an entry still in flight");

  // A wake report is never the final result of its command.
  a_woken_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.status == ST_WOKEN |-> !out_r.last)
    else $error("wake report marked as final result");

endmodule

// ===== hdl/sleep_queue_with_tick_wakeup.sv =====
// Top level of the sleep queue: controller and datapath.
// Enqueue: result the cycle after acceptance; busy stays low, so one enqueue per cycle while no walk runs.
// Dequeue, remove and tick walk the queue memory one entry per cycle through its single
// read port: busy through the scan, drain and finish states (only finish on an empty queue).
// Wake reports leave during the walk; the closing result appears as busy falls.
// Synchronous active-low reset empties the queue; memory contents are not cleared.
module sleep_queue_with_tick_wakeup
  import sq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 16,
  parameter int unsigned HANDLE_WIDTH = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer.
  sq_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_item.cmd),
    .sts_i  (dp_sts),
    .cmd_o  (dp_cmd),
    .busy   (busy)
  );

  // Storage and result generation.
  sq_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd_i     (dp_cmd),
    .sts_o     (dp_sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
